/* hdl/tssr_pkg.sv */
// Shared types, constants and helpers of the tile and sprite scanline renderer.
// Used by every module of the block but tssr_ram; depends on nothing.
`default_nettype none
package tssr_pkg;

   // defaults of the top-level parameters
   localparam int SPRITE_ENTRIES_DEF   = 40;
   localparam int SPRITES_PER_LINE_DEF = 10;
   localparam int LINE_WIDTH_DEF       = 160;

   localparam int TILE_BYTES  = 8192;
   localparam int TILE_AW     = 13;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 8;
   localparam int GROUP_W     = 5;
   localparam int WINDOW_LINES    = 144;
   localparam int SPRITE_Y_OFFSET = 16;
   localparam int SPRITE_X_OFFSET = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LCD_CONTROL  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BG_PALETTE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OBJ_PAL_ZERO = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OBJ_PAL_ONE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCROLL_X     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SCROLL_Y     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_TOP   = 3'd6;

   localparam logic [7:0] LCD_CONTROL_RST  = 8'd0;
   localparam logic [7:0] BG_PALETTE_RST   = 8'd27;
   localparam logic [7:0] OBJ_PALETTE_RST  = 8'd228;

   // lcd_control bit positions
   localparam int LCD_BG_ON     = 0;
   localparam int LCD_TALL      = 2;
   localparam int LCD_BG_MAP    = 3;
   localparam int LCD_TILE_DATA = 4;
   localparam int LCD_WIN_ON    = 5;
   localparam int LCD_WIN_MAP   = 6;

   // sprite flag bit positions
   localparam int FLAG_BEHIND = 7;
   localparam int FLAG_YFLIP  = 6;
   localparam int FLAG_XFLIP  = 5;
   localparam int FLAG_PAL    = 4;

   typedef enum logic [1:0] {
      OP_TILE_WRITE   = 2'd0,
      OP_SPRITE_WRITE = 2'd1,
      OP_RENDER       = 2'd2,
      OP_NONE         = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE,
      ST_BG_MAP, ST_BG_LO, ST_BG_HI, ST_BG_CAP, ST_BG_PIX,
      ST_SP_Y, ST_SP_X, ST_SP_T, ST_SP_F, ST_SP_CHK,
      ST_SP_LO, ST_SP_HI, ST_SP_CAP, ST_SP_RD, ST_SP_WR, ST_SP_NEXT,
      ST_OUT_RD, ST_OUT_ACC, ST_OUT_PUT
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic accept;
      logic bg_map;
      logic bg_lo;
      logic bg_hi;
      logic bg_cap;
      logic bg_pix;
      logic sp_y;
      logic sp_x;
      logic sp_t;
      logic sp_f;
      logic sp_chk;
      logic sp_lo;
      logic sp_hi;
      logic sp_cap;
      logic sp_rd;
      logic sp_wr;
      logic sp_next;
      logic out_rd;
      logic out_acc;
      logic out_put;
   } cmd_type;

   typedef struct packed {
      logic   clr_last;
      logic   req_fire;
      op_type req_op;
      logic   bg_on;
      logic   pix_last;
      logic   next_tile;
      logic   sp_take;
      logic   sp_visible;
      logic   sp_more;
      logic   spx_draw;
      logic   spx_last;
      logic   out_slot;
      logic   out_last_group;
   } sts_type;

   // one pixel of the line buffer
   typedef struct packed {
      logic [1:0] bg;
      logic [1:0] shade;
      logic       owned;
      logic [7:0] ox;
   } line_entry_type;

   function automatic logic [1:0] pal_shade(input logic [7:0] pal, input logic [1:0] colour);
      logic [1:0] s;
      unique case (colour)
         2'd0: s = pal[1:0];
         2'd1: s = pal[3:2];
         2'd2: s = pal[5:4];
         2'd3: s = pal[7:6];
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

/* hdl/tssr_req_if.sv */
// Request channel of the renderer: valid/ready and the request word.
// Stands alone; no package use.
`default_nettype none
interface tssr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [12:0] address;
   logic [7:0]  data;
   logic [7:0]  line;

   modport source (output valid, operation, address, data, line, input ready);
   modport sink   (input valid, operation, address, data, line, output ready);
endinterface
`default_nettype wire

/* hdl/tssr_rsp_if.sv */
// Response channel of the renderer: valid/ready and one pixel-group word.
// Stands alone; no package use.
`default_nettype none
interface tssr_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  group_index;
   logic [15:0] pixel_shades;
   logic        last;

   modport source (output valid, group_index, pixel_shades, last, input ready);
   modport sink   (input valid, group_index, pixel_shades, last, output ready);
endinterface
`default_nettype wire

/* hdl/tssr_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module tssr_ram #(
   parameter int WIDTH      = 8,
   parameter int DEPTH      = 256,
   parameter int ADDR_WIDTH = 8
) (
   input  wire logic                  clock,
   input  wire logic                  we,
   input  wire logic [ADDR_WIDTH-1:0] waddr,
   input  wire logic [WIDTH-1:0]      wdata,
   input  wire logic [ADDR_WIDTH-1:0] raddr,
   output logic      [WIDTH-1:0]      rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

/* hdl/tssr_ctrl.sv */
// Sequencer of the renderer: clearing pass, request accept, background,
// sprite scan and output phases. Uses tssr_pkg; drives tssr_datapath.
`default_nettype none
module tssr_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tssr_pkg::sts_type sts,
   output tssr_pkg::cmd_type      cmd
);
   tssr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tssr_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tssr_pkg::ST_CLEAR: begin
            if (sts.clr_last) state_in = tssr_pkg::ST_IDLE;
         end
         tssr_pkg::ST_IDLE: begin
            // the line register loads on this edge; fetch first, decide per pixel
            if (sts.req_fire && sts.req_op == tssr_pkg::OP_RENDER) begin
               state_in = tssr_pkg::ST_BG_MAP;
            end
         end
         tssr_pkg::ST_BG_MAP: state_in = tssr_pkg::ST_BG_LO;
         tssr_pkg::ST_BG_LO:  state_in = tssr_pkg::ST_BG_HI;
         tssr_pkg::ST_BG_HI:  state_in = tssr_pkg::ST_BG_CAP;
         tssr_pkg::ST_BG_CAP: state_in = tssr_pkg::ST_BG_PIX;
         tssr_pkg::ST_BG_PIX: begin
            if (sts.pix_last) begin
               state_in = tssr_pkg::ST_SP_Y;
            end else if (sts.bg_on && sts.next_tile) begin
               state_in = tssr_pkg::ST_BG_MAP;
            end
         end
         tssr_pkg::ST_SP_Y: state_in = tssr_pkg::ST_SP_X;
         tssr_pkg::ST_SP_X: state_in = tssr_pkg::ST_SP_T;
         tssr_pkg::ST_SP_T: state_in = tssr_pkg::ST_SP_F;
         tssr_pkg::ST_SP_F: state_in = tssr_pkg::ST_SP_CHK;
         tssr_pkg::ST_SP_CHK: begin
            state_in = (sts.sp_take && sts.sp_visible) ? tssr_pkg::ST_SP_LO
                                                       : tssr_pkg::ST_SP_NEXT;
         end
         tssr_pkg::ST_SP_LO:  state_in = tssr_pkg::ST_SP_HI;
         tssr_pkg::ST_SP_HI:  state_in = tssr_pkg::ST_SP_CAP;
         tssr_pkg::ST_SP_CAP: state_in = tssr_pkg::ST_SP_RD;
         tssr_pkg::ST_SP_RD: begin
            if (sts.spx_draw) begin
               state_in = tssr_pkg::ST_SP_WR;
            end else if (sts.spx_last) begin
               state_in = tssr_pkg::ST_SP_NEXT;
            end
         end
         tssr_pkg::ST_SP_WR: begin
            state_in = sts.spx_last ? tssr_pkg::ST_SP_NEXT : tssr_pkg::ST_SP_RD;
         end
         tssr_pkg::ST_SP_NEXT: begin
            state_in = sts.sp_more ? tssr_pkg::ST_SP_Y : tssr_pkg::ST_OUT_RD;
         end
         tssr_pkg::ST_OUT_RD: state_in = tssr_pkg::ST_OUT_ACC;
         tssr_pkg::ST_OUT_ACC: begin
            state_in = sts.spx_last ? tssr_pkg::ST_OUT_PUT : tssr_pkg::ST_OUT_RD;
         end
         tssr_pkg::ST_OUT_PUT: begin
            if (sts.out_slot) begin
               state_in = sts.out_last_group ? tssr_pkg::ST_IDLE : tssr_pkg::ST_OUT_RD;
            end
         end
         default: state_in = tssr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         tssr_pkg::ST_CLEAR:   cmd.clr_step = 1'b1;
         tssr_pkg::ST_IDLE:    cmd.accept   = 1'b1;
         tssr_pkg::ST_BG_MAP:  cmd.bg_map   = 1'b1;
         tssr_pkg::ST_BG_LO:   cmd.bg_lo    = 1'b1;
         tssr_pkg::ST_BG_HI:   cmd.bg_hi    = 1'b1;
         tssr_pkg::ST_BG_CAP:  cmd.bg_cap   = 1'b1;
         tssr_pkg::ST_BG_PIX:  cmd.bg_pix   = 1'b1;
         tssr_pkg::ST_SP_Y:    cmd.sp_y     = 1'b1;
         tssr_pkg::ST_SP_X:    cmd.sp_x     = 1'b1;
         tssr_pkg::ST_SP_T:    cmd.sp_t     = 1'b1;
         tssr_pkg::ST_SP_F:    cmd.sp_f     = 1'b1;
         tssr_pkg::ST_SP_CHK:  cmd.sp_chk   = 1'b1;
         tssr_pkg::ST_SP_LO:   cmd.sp_lo    = 1'b1;
         tssr_pkg::ST_SP_HI:   cmd.sp_hi    = 1'b1;
         tssr_pkg::ST_SP_CAP:  cmd.sp_cap   = 1'b1;
         tssr_pkg::ST_SP_RD:   cmd.sp_rd    = 1'b1;
         tssr_pkg::ST_SP_WR:   cmd.sp_wr    = 1'b1;
         tssr_pkg::ST_SP_NEXT: cmd.sp_next  = 1'b1;
         tssr_pkg::ST_OUT_RD:  cmd.out_rd   = 1'b1;
         tssr_pkg::ST_OUT_ACC: cmd.out_acc  = 1'b1;
         tssr_pkg::ST_OUT_PUT: cmd.out_put  = 1'b1;
         default:              cmd          = '0;
      endcase
   end
endmodule
`default_nettype wire

/* hdl/tssr_datapath.sv */
// Datapath of the renderer: config registers, tile/sprite/line RAMs, fetch
// and pixel logic, output register. Uses tssr_pkg, tssr_ram and both channels.
`default_nettype none
module tssr_datapath #(
   parameter int SPRITE_ENTRIES   = tssr_pkg::SPRITE_ENTRIES_DEF,
   parameter int SPRITES_PER_LINE = tssr_pkg::SPRITES_PER_LINE_DEF,
   parameter int LINE_WIDTH       = tssr_pkg::LINE_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   tssr_req_if.sink                                 req_chan,
   tssr_rsp_if.source                               rsp_chan,
   input  wire logic                                csr_write_enable,
   input  wire logic [tssr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tssr_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  wire tssr_pkg::cmd_type                   cmd,
   output tssr_pkg::sts_type                        sts
);
   localparam int SIW     = (SPRITE_ENTRIES > 1) ? $clog2(SPRITE_ENTRIES) : 1;
   localparam int SAW     = SIW + 2;
   localparam int SBYTES  = SPRITE_ENTRIES * 4;
   localparam int CNTW    = $clog2(SPRITES_PER_LINE + 1);
   localparam int LAW     = $clog2(LINE_WIDTH);
   localparam int GROUPS  = (LINE_WIDTH + 7) / 8;
   localparam int LEW     = $bits(tssr_pkg::line_entry_type);

   // configuration
   logic [7:0] lcd_ff, bgp_ff, obp0_ff, obp1_ff, scx_ff, scy_ff, wty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lcd_ff  <= tssr_pkg::LCD_CONTROL_RST;
         bgp_ff  <= tssr_pkg::BG_PALETTE_RST;
         obp0_ff <= tssr_pkg::OBJ_PALETTE_RST;
         obp1_ff <= tssr_pkg::OBJ_PALETTE_RST;
         scx_ff  <= '0;
         scy_ff  <= '0;
         wty_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tssr_pkg::REG_LCD_CONTROL:  lcd_ff  <= csr_write_data;
            tssr_pkg::REG_BG_PALETTE:   bgp_ff  <= csr_write_data;
            tssr_pkg::REG_OBJ_PAL_ZERO: obp0_ff <= csr_write_data;
            tssr_pkg::REG_OBJ_PAL_ONE:  obp1_ff <= csr_write_data;
            tssr_pkg::REG_SCROLL_X:     scx_ff  <= csr_write_data;
            tssr_pkg::REG_SCROLL_Y:     scy_ff  <= csr_write_data;
            tssr_pkg::REG_WINDOW_TOP:   wty_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // working registers
   logic [tssr_pkg::TILE_AW-1:0] clr_ff, fetch_addr_ff, fetch_addr_in;
   logic [7:0]      line_ff, xp_ff, lo_ff, hi_ff;
   logic [7:0]      sy_ff, sx_ff, st_ff, sf_ff;
   logic [SIW-1:0]  idx_ff;
   logic [CNTW-1:0] cnt_ff;
   logic [2:0]      p_ff;
   logic [tssr_pkg::GROUP_W-1:0] g_ff;
   logic [15:0]     word_ff;
   logic            rsp_valid_ff;
   logic [tssr_pkg::GROUP_W-1:0] rsp_group_ff;
   logic [15:0]     rsp_shades_ff;
   logic            rsp_last_ff;

   logic [7:0] tile_rdata, sprite_rdata;
   logic [LEW-1:0] line_rdata;
   tssr_pkg::line_entry_type entry;
   assign entry = tssr_pkg::line_entry_type'(line_rdata);

   tssr_pkg::op_type req_op;
   logic req_fire;
   assign req_op   = tssr_pkg::op_type'(req_chan.operation);
   assign req_chan.ready = cmd.accept;
   assign req_fire = req_chan.valid && cmd.accept;

   // background addressing
   logic       win, bg_on, map_sel;
   logic [7:0] wdiff, xm, ym, tnum;
   logic [tssr_pkg::TILE_AW-1:0] map_addr, data_addr;
   logic [2:0] bg_bit;
   logic [1:0] bg_shade;

   assign wdiff = line_ff - wty_ff;
   assign win   = lcd_ff[tssr_pkg::LCD_WIN_ON] && (line_ff >= wty_ff) &&
                  (wdiff < 8'(tssr_pkg::WINDOW_LINES));
   assign bg_on = win || lcd_ff[tssr_pkg::LCD_BG_ON];
   assign xm    = win ? xp_ff : xp_ff + scx_ff;
   assign ym    = win ? wdiff : line_ff + scy_ff;
   assign map_sel  = win ? lcd_ff[tssr_pkg::LCD_WIN_MAP] : lcd_ff[tssr_pkg::LCD_BG_MAP];
   // map base sits at byte 0x1800 of tile memory, second map 0x400 above it
   assign map_addr = {2'b11, map_sel, ym[7:3], xm[7:3]};
   assign tnum     = tile_rdata;
   assign data_addr = {lcd_ff[tssr_pkg::LCD_TILE_DATA] ? 1'b0 : ~tnum[7],
                       tnum, ym[2:0], 1'b0};
   assign bg_bit   = ~xm[2:0];
   assign bg_shade = bg_on ? tssr_pkg::pal_shade(bgp_ff, {hi_ff[bg_bit], lo_ff[bg_bit]})
                           : 2'd0;

   // sprite geometry
   logic       tall, covers, sp_take;
   logic [8:0] lt, dy;
   logic [3:0] row, rowf;
   logic [7:0] tilef;
   logic [tssr_pkg::TILE_AW-1:0] sp_addr;
   logic [9:0] colv;
   logic       col_ok, spx_draw;
   logic [7:0] col;
   logic [2:0] sp_bit;
   logic [1:0] sp_colour, sp_shade;
   logic       sp_pass;

   assign tall   = lcd_ff[tssr_pkg::LCD_TALL];
   assign lt     = {1'b0, line_ff} + 9'(tssr_pkg::SPRITE_Y_OFFSET);
   assign dy     = lt - {1'b0, sy_ff};
   assign covers = (lt >= {1'b0, sy_ff}) && (dy < (tall ? 9'd16 : 9'd8));
   assign sp_take = covers && (cnt_ff < CNTW'(SPRITES_PER_LINE));
   assign row    = dy[3:0];
   assign rowf   = sf_ff[tssr_pkg::FLAG_YFLIP] ? ((tall ? 4'd15 : 4'd7) - row) : row;
   assign tilef  = tall ? {st_ff[7:1], 1'b0} : st_ff;
   assign sp_addr = tssr_pkg::TILE_AW'({tilef, 4'b0000}) + tssr_pkg::TILE_AW'({rowf, 1'b0});

   assign colv   = 10'(sx_ff) + 10'(p_ff);
   assign col    = 8'(colv - 10'(tssr_pkg::SPRITE_X_OFFSET));
   assign col_ok = (colv >= 10'(tssr_pkg::SPRITE_X_OFFSET)) &&
                   ((colv - 10'(tssr_pkg::SPRITE_X_OFFSET)) < 10'(LINE_WIDTH));
   assign sp_bit = sf_ff[tssr_pkg::FLAG_XFLIP] ? p_ff : ~p_ff;
   assign sp_colour = {hi_ff[sp_bit], lo_ff[sp_bit]};
   assign spx_draw  = col_ok && (sp_colour != 2'd0);
   assign sp_shade  = tssr_pkg::pal_shade(sf_ff[tssr_pkg::FLAG_PAL] ? obp1_ff : obp0_ff,
                                          sp_colour);
   // leftmost sprite wins, later table entry wins a tie
   assign sp_pass = !(sf_ff[tssr_pkg::FLAG_BEHIND] && entry.bg != bgp_ff[1:0]) &&
                    !(entry.owned && entry.ox < sx_ff);

   // output gathering
   logic [7:0] ocol;
   logic       ocol_ok, out_slot, out_last_group;
   assign ocol    = {g_ff, p_ff};
   assign ocol_ok = 9'(ocol) < 9'(LINE_WIDTH);
   assign out_slot = !rsp_valid_ff || rsp_chan.ready;
   assign out_last_group = g_ff == tssr_pkg::GROUP_W'(GROUPS - 1);

   // tile memory ports
   logic tile_we;
   logic [tssr_pkg::TILE_AW-1:0] tile_waddr, tile_raddr;
   logic [7:0] tile_wdata;

   always_comb begin
      tile_we    = 1'b0;
      tile_waddr = req_chan.address;
      tile_wdata = req_chan.data;
      if (cmd.clr_step) begin
         tile_we    = 1'b1;
         tile_waddr = clr_ff;
         tile_wdata = '0;
      end else if (req_fire && req_op == tssr_pkg::OP_TILE_WRITE) begin
         tile_we = 1'b1;
      end
   end

   always_comb begin
      fetch_addr_in = fetch_addr_ff;
      tile_raddr    = map_addr;
      priority if (cmd.bg_lo) begin
         tile_raddr    = data_addr;
         fetch_addr_in = data_addr;
      end else if (cmd.sp_lo) begin
         tile_raddr    = sp_addr;
         fetch_addr_in = sp_addr;
      end else if (cmd.bg_hi || cmd.sp_hi) begin
         tile_raddr = fetch_addr_ff | tssr_pkg::TILE_AW'(1);
      end else begin
         tile_raddr = map_addr;
      end
   end

   tssr_ram #(.WIDTH(8), .DEPTH(tssr_pkg::TILE_BYTES), .ADDR_WIDTH(tssr_pkg::TILE_AW))
   u_tile_ram (
      .clock (clock),
      .we    (tile_we),
      .waddr (tile_waddr),
      .wdata (tile_wdata),
      .raddr (tile_raddr),
      .rdata (tile_rdata)
   );

   // sprite table ports
   logic sprite_we;
   logic [SAW-1:0] sprite_waddr, sprite_raddr;
   logic [7:0] sprite_wdata;
   logic [1:0] field;

   always_comb begin
      sprite_we    = 1'b0;
      sprite_waddr = req_chan.address[SAW-1:0];
      sprite_wdata = req_chan.data;
      if (cmd.clr_step) begin
         sprite_we    = clr_ff < tssr_pkg::TILE_AW'(SBYTES);
         sprite_waddr = clr_ff[SAW-1:0];
         sprite_wdata = '0;
      end else if (req_fire && req_op == tssr_pkg::OP_SPRITE_WRITE) begin
         sprite_we = req_chan.address < tssr_pkg::TILE_AW'(SBYTES);
      end
   end

   always_comb begin
      priority if (cmd.sp_x)      field = 2'd1;
      else if (cmd.sp_t)          field = 2'd2;
      else if (cmd.sp_f)          field = 2'd3;
      else                        field = 2'd0;
   end
   assign sprite_raddr = {idx_ff, field};

   tssr_ram #(.WIDTH(8), .DEPTH(SBYTES), .ADDR_WIDTH(SAW)) u_sprite_ram (
      .clock (clock),
      .we    (sprite_we),
      .waddr (sprite_waddr),
      .wdata (sprite_wdata),
      .raddr (sprite_raddr),
      .rdata (sprite_rdata)
   );

   // line buffer ports
   logic line_we;
   logic [LAW-1:0] line_waddr, line_raddr;
   tssr_pkg::line_entry_type line_wentry;

   always_comb begin
      line_we     = 1'b0;
      line_waddr  = xp_ff[LAW-1:0];
      line_wentry = '{bg: bg_shade, shade: bg_shade, owned: 1'b0, ox: 8'd0};
      if (cmd.bg_pix) begin
         line_we = 1'b1;
      end else if (cmd.sp_wr) begin
         line_we     = sp_pass;
         line_waddr  = col[LAW-1:0];
         line_wentry = '{bg: entry.bg, shade: sp_shade, owned: 1'b1, ox: sx_ff};
      end
   end
   assign line_raddr = cmd.sp_rd ? col[LAW-1:0] : ocol[LAW-1:0];

   tssr_ram #(.WIDTH(LEW), .DEPTH(LINE_WIDTH), .ADDR_WIDTH(LAW)) u_line_ram (
      .clock (clock),
      .we    (line_we),
      .waddr (line_waddr),
      .wdata (line_wentry),
      .raddr (line_raddr),
      .rdata (line_rdata)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) clr_ff <= clr_ff + 1'b1;
         if (req_fire && req_op == tssr_pkg::OP_RENDER) cnt_ff <= '0;
         else if (cmd.sp_chk && sp_take) cnt_ff <= cnt_ff + 1'b1;
         if (cmd.out_put && out_slot) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready)     rsp_valid_ff <= 1'b0;
      end
   end

   // payload and walking registers
   always_ff @(posedge clock) begin
      fetch_addr_ff <= fetch_addr_in;
      if (req_fire && req_op == tssr_pkg::OP_RENDER) begin
         line_ff <= req_chan.line;
         xp_ff   <= '0;
         idx_ff  <= '0;
         g_ff    <= '0;
         p_ff    <= '0;
      end
      if (cmd.bg_hi || cmd.sp_hi)   lo_ff <= tile_rdata;
      if (cmd.bg_cap || cmd.sp_cap) hi_ff <= tile_rdata;
      if (cmd.bg_pix) xp_ff <= xp_ff + 1'b1;
      if (cmd.sp_x)   sy_ff <= sprite_rdata;
      if (cmd.sp_t)   sx_ff <= sprite_rdata;
      if (cmd.sp_f)   st_ff <= sprite_rdata;
      if (cmd.sp_chk) sf_ff <= sprite_rdata;
      if (cmd.sp_cap || cmd.sp_next) p_ff <= '0;
      if ((cmd.sp_rd && !spx_draw) || cmd.sp_wr || cmd.out_acc) p_ff <= p_ff + 1'b1;
      if (cmd.sp_next) idx_ff <= idx_ff + 1'b1;
      if (cmd.out_acc) word_ff <= {ocol_ok ? entry.shade : 2'd0, word_ff[15:2]};
      if (cmd.out_put && out_slot) begin
         rsp_group_ff  <= g_ff;
         rsp_shades_ff <= word_ff;
         rsp_last_ff   <= out_last_group;
         g_ff          <= g_ff + 1'b1;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.group_index  = rsp_group_ff;
   assign rsp_chan.pixel_shades = rsp_shades_ff;
   assign rsp_chan.last         = rsp_last_ff;

   always_comb begin
      sts.clr_last       = clr_ff == tssr_pkg::TILE_AW'(tssr_pkg::TILE_BYTES - 1);
      sts.req_fire       = req_fire;
      sts.req_op         = req_op;
      sts.bg_on          = bg_on;
      sts.pix_last       = xp_ff == 8'(LINE_WIDTH - 1);
      sts.next_tile      = xm[2:0] == 3'd7;
      sts.sp_take        = sp_take;
      sts.sp_visible     = sx_ff != 8'd0;
      sts.sp_more        = (idx_ff != SIW'(SPRITE_ENTRIES - 1)) &&
                           (cnt_ff < CNTW'(SPRITES_PER_LINE));
      sts.spx_draw       = spx_draw;
      sts.spx_last       = p_ff == 3'd7;
      sts.out_slot       = out_slot;
      sts.out_last_group = out_last_group;
   end
endmodule
`default_nettype wire

/* hdl/tile_sprite_scanline_renderer.sv */
// Tile and sprite scanline renderer, top level.
// Request channel (req_chan) carries one word per operation: write a tile
// memory byte, write a sprite table byte, or render one screen line.
// Configuration registers are written through csr_write_enable/csr_index/
// csr_write_data; the user must write them only while the block is idle,
// which the block itself does not enforce. A write word is taken while idle
// and leaves the block idle for the next word. A render word produces one
// response word (rsp_chan) per group of eight pixels, leftmost group first,
// with last set on the final group. A render runs the background walk (a
// map entry and two data bytes fetched per tile while background or window
// is on), the sprite table scan (four bytes read per entry, then a fetch and
// a pixel walk per drawn sprite) and the readout group by group, all paced
// by the single read port of each RAM. The next word is taken once the last
// group sits in the output register. After reset a clearing pass zeroes
// tile memory and the sprite table; req_chan.ready stays low during it.
// When the receiver stalls, the current group holds in the output register
// and the readout waits.
`default_nettype none
module tile_sprite_scanline_renderer #(
   parameter int SPRITE_ENTRIES   = tssr_pkg::SPRITE_ENTRIES_DEF,
   parameter int SPRITES_PER_LINE = tssr_pkg::SPRITES_PER_LINE_DEF,
   parameter int LINE_WIDTH       = tssr_pkg::LINE_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   tssr_req_if.sink                             req_chan,
   tssr_rsp_if.source                           rsp_chan,
   input  wire logic                            csr_write_enable,
   input  wire logic [tssr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tssr_pkg::CSR_DATA_W-1:0] csr_write_data
);
   tssr_pkg::cmd_type cmd;
   tssr_pkg::sts_type sts;

   tssr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   tssr_datapath #(
      .SPRITE_ENTRIES   (SPRITE_ENTRIES),
      .SPRITES_PER_LINE (SPRITES_PER_LINE),
      .LINE_WIDTH       (LINE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .sts              (sts)
   );
endmodule
`default_nettype wire

/* hdl/tssr_checker.sv */
// Port-level checks of the renderer, bound to the top level.
// Depends on tile_sprite_scanline_renderer's channel ports.
`default_nettype none
module tssr_checker #(
   parameter int LINE_WIDTH = tssr_pkg::LINE_WIDTH_DEF
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [4:0]  rsp_group,
   input wire logic [15:0] rsp_shades,
   input wire logic        rsp_last
);
   localparam int GROUPS = (LINE_WIDTH + 7) / 8;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_group) &&
                                  $stable(rsp_shades) && $stable(rsp_last))
      else $error("response word changed while stalled");

   a_last_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_group == 5'(GROUPS - 1))))
      else $error("last flag does not match final group");

   a_group_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_group < 5'(GROUPS)))
      else $error("group index out of range");

   a_busy_mid_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken in the middle of a line");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
endmodule

bind tile_sprite_scanline_renderer tssr_checker #(.LINE_WIDTH(LINE_WIDTH)) u_tssr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_group  (rsp_chan.group_index),
   .rsp_shades (rsp_chan.pixel_shades),
   .rsp_last   (rsp_chan.last)
);
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench of the tile and sprite scanline renderer.
// Depends on tssr_pkg, tssr_req_if, tssr_rsp_if and tile_sprite_scanline_renderer.
// Mirrors the tile memory, sprite table and registers to predict every pixel group.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tssr_pkg::*;

   localparam int GROUPS      = 20;
   localparam int PIXELS      = 160;
   localparam int MAP_BASE    = 'h1800;
   localparam int MAP_SIZE    = 'h400;
   localparam int SIGNED_BASE = 'h1000;
   localparam int IDLE_LIMIT  = 30000;
   localparam int HOLD_CYCLES = 3000;

   typedef struct packed {
      logic [4:0]  group_index;
      logic [15:0] pixel_shades;
      logic        last;
   } group_word_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   tssr_req_if req_chan ();
   tssr_rsp_if rsp_chan ();

   tile_sprite_scanline_renderer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan.sink),
      .rsp_chan         (rsp_chan.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // mirror of the block's state
   logic [7:0] tile_mem [TILE_BYTES];
   logic [7:0] sprite_tab [160];
   logic [7:0] regs [7];
   group_word_t expected_groups [$];

   int  errors = 0;
   int  idle_cycles = 0;
   bit  hold_req = 1'b0;
   bit  quiet_rx = 1'b0;
   bit  quiet_tx = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.operation = OP_NONE;
      req_chan.address = '0;
      req_chan.data = '0;
      req_chan.line = '0;
      rsp_chan.ready = 1'b0;
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
      errors++;
   endtask

   function automatic void predict_line(logic [7:0] ln);
      logic [1:0] bg [PIXELS];
      logic [1:0] shades [PIXELS];
      logic [31:0] sel [10];
      logic [31:0] v;
      int cnt, height, top, left, row, tile, flags, addr, xm, ym, map, colour, bit_pos;
      int lo, hi, col, j;
      logic [7:0] pal;
      bit win, tall;
      group_word_t w;
      tall = regs[REG_LCD_CONTROL][LCD_TALL];
      height = tall ? 16 : 8;
      win = regs[REG_LCD_CONTROL][LCD_WIN_ON] && ln >= regs[REG_WINDOW_TOP] &&
            (int'(ln) - int'(regs[REG_WINDOW_TOP])) < WINDOW_LINES;
      // pick sprites in table order, then order by falling x
      cnt = 0;
      for (int i = 0; i < 40 && cnt < 10; i++) begin
         top = int'(sprite_tab[i*4]) - 16;
         if (int'(ln) < top || int'(ln) >= top + height) continue;
         sel[cnt] = {sprite_tab[i*4+3], sprite_tab[i*4+2], sprite_tab[i*4+1], sprite_tab[i*4]};
         cnt++;
      end
      for (int i = 1; i < cnt; i++) begin
         v = sel[i];
         j = i;
         while (j > 0 && sel[j-1][15:8] < v[15:8]) begin
            sel[j] = sel[j-1];
            j--;
         end
         sel[j] = v;
      end
      for (int x = 0; x < PIXELS; x++) begin
         if (win) begin
            xm = x & 255;
            ym = int'(ln) - int'(regs[REG_WINDOW_TOP]);
            map = regs[REG_LCD_CONTROL][LCD_WIN_MAP];
         end else if (!regs[REG_LCD_CONTROL][LCD_BG_ON]) begin
            bg[x] = 2'd0;
            continue;
         end else begin
            xm = (x + regs[REG_SCROLL_X]) & 255;
            ym = (int'(ln) + regs[REG_SCROLL_Y]) & 255;
            map = regs[REG_LCD_CONTROL][LCD_BG_MAP];
         end
         tile = tile_mem[(MAP_BASE + map*MAP_SIZE + (ym/8)*32 + xm/8) & 8191];
         if (regs[REG_LCD_CONTROL][LCD_TILE_DATA]) addr = tile*16;
         else addr = SIGNED_BASE + tile*16 - ((tile & 'h80) ? 'h1000 : 0);
         addr += (ym & 7) * 2;
         bit_pos = 7 - (xm & 7);
         colour = (tile_mem[(addr+1) & 8191][bit_pos] << 1) | tile_mem[addr & 8191][bit_pos];
         bg[x] = regs[REG_BG_PALETTE][2*colour +: 2];
      end
      shades = bg;
      for (int i = 0; i < cnt; i++) begin
         top = int'(sel[i][7:0]) - 16;
         left = int'(sel[i][15:8]) - 8;
         tile = sel[i][23:16];
         flags = sel[i][31:24];
         row = (int'(ln) - top) & 15;
         pal = flags[FLAG_PAL] ? regs[REG_OBJ_PAL_ONE] : regs[REG_OBJ_PAL_ZERO];
         if (left < -7) continue;
         if (tall) tile &= 'hFE;
         if (flags[FLAG_YFLIP]) row = (tall ? 15 : 7) - row;
         addr = tile*16 + row*2;
         lo = tile_mem[addr & 8191];
         hi = tile_mem[(addr+1) & 8191];
         for (int p = 0; p < 8; p++) begin
            col = left + p;
            bit_pos = flags[FLAG_XFLIP] ? p : 7 - p;
            if (col < 0 || col >= PIXELS) continue;
            colour = (((hi >> bit_pos) & 1) << 1) | ((lo >> bit_pos) & 1);
            if (colour == 0) continue;
            if (flags[FLAG_BEHIND] && bg[col] != regs[REG_BG_PALETTE][1:0]) continue;
            shades[col] = pal[2*colour +: 2];
         end
      end
      for (int g = 0; g < GROUPS; g++) begin
         w.group_index = g[4:0];
         for (int p = 0; p < 8; p++) w.pixel_shades[2*p +: 2] = shades[g*8 + p];
         w.last = (g == GROUPS - 1);
         expected_groups.push_back(w);
      end
   endfunction

   // drive one request word and update the mirror once it is taken
   task automatic send_word(op_type op, logic [12:0] addr, logic [7:0] data, logic [7:0] ln);
      int gap, r;
      r = $urandom_range(0, 99);
      gap = (quiet_tx || r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(20, 80);
      if (gap > 0) begin
         @(negedge clock) req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.operation <= op;
      req_chan.address <= addr;
      req_chan.data <= data;
      req_chan.line <= ln;
      do @(posedge clock); while (!req_chan.ready);
      case (op)
         OP_TILE_WRITE:   tile_mem[addr] = data;
         OP_SPRITE_WRITE: if (addr < 160) sprite_tab[addr] = data;
         OP_RENDER:       predict_line(ln);
         default: ;
      endcase
   endtask

   task automatic drop_valid();
      @(negedge clock) req_chan.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      drop_valid();
      wait (expected_groups.size() == 0);
      repeat (64) @(posedge clock);
   endtask

   task automatic set_reg(logic [CSR_IDX_W-1:0] idx, logic [7:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock) csr_write_enable <= 1'b0;
      regs[idx] = value;
   endtask

   task automatic set_all(logic [7:0] lcd, logic [7:0] bgp, logic [7:0] p0, logic [7:0] p1,
                          logic [7:0] sx, logic [7:0] sy, logic [7:0] wt);
      wait_drained();
      set_reg(REG_LCD_CONTROL, lcd);
      set_reg(REG_BG_PALETTE, bgp);
      set_reg(REG_OBJ_PAL_ZERO, p0);
      set_reg(REG_OBJ_PAL_ONE, p1);
      set_reg(REG_SCROLL_X, sx);
      set_reg(REG_SCROLL_Y, sy);
      set_reg(REG_WINDOW_TOP, wt);
   endtask

   task automatic random_word();
      int r, a;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         send_word(OP_TILE_WRITE, 13'($urandom_range(MAP_BASE, 8191)), 8'($urandom), 8'd0);
      end else if (r < 55) begin
         send_word(OP_TILE_WRITE, 13'($urandom), 8'($urandom), 8'($urandom));
      end else if (r < 80) begin
         a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 159);
         // bias y and x so that sprites land on the screen
         case (a % 4)
            0: send_word(OP_SPRITE_WRITE, 13'(a), 8'($urandom_range(0, 175)), 8'($urandom));
            1: send_word(OP_SPRITE_WRITE, 13'(a), 8'($urandom_range(0, 175)), 8'($urandom));
            default: send_word(OP_SPRITE_WRITE, 13'(a), 8'($urandom), 8'($urandom));
         endcase
      end else if (r < 97) begin
         send_word(OP_RENDER, 13'($urandom), 8'($urandom),
                   ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 143)));
      end else begin
         send_word(OP_NONE, 13'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   task automatic test_directed();
      send_word(OP_RENDER, '0, '0, 8'd0);
      // tile 1 rows, map entries for both maps, signed tile 0x80
      send_word(OP_TILE_WRITE, 13'h0010, 8'hF0, 8'd0);
      send_word(OP_TILE_WRITE, 13'h0011, 8'h3C, 8'd0);
      send_word(OP_TILE_WRITE, 13'h0800, 8'hAA, 8'd0);
      send_word(OP_TILE_WRITE, 13'h1800, 8'h01, 8'd0);
      send_word(OP_TILE_WRITE, 13'h1C00, 8'h80, 8'd0);
      send_word(OP_TILE_WRITE, 13'h1FFF, 8'hFF, 8'd0);
      // one flipped behind sprite on screen, one clipped right
      send_word(OP_SPRITE_WRITE, 13'd0, 8'd16, 8'd0);
      send_word(OP_SPRITE_WRITE, 13'd1, 8'd12, 8'd0);
      send_word(OP_SPRITE_WRITE, 13'd2, 8'd1, 8'd0);
      send_word(OP_SPRITE_WRITE, 13'd3, 8'hF0, 8'd0);
      send_word(OP_SPRITE_WRITE, 13'd4, 8'd16, 8'd0);
      send_word(OP_SPRITE_WRITE, 13'd5, 8'd164, 8'd0);
      send_word(OP_SPRITE_WRITE, 13'd6, 8'd1, 8'd0);
      send_word(OP_SPRITE_WRITE, 13'd159, 8'hFF, 8'd0);
      send_word(OP_SPRITE_WRITE, 13'd160, 8'h55, 8'd0);
      send_word(OP_SPRITE_WRITE, 13'h1FFF, 8'h55, 8'd0);
      send_word(OP_NONE, 13'h1FFF, 8'hFF, 8'hFF);
      set_all(8'h15, 8'hE4, 8'h1B, 8'hE4, 8'd0, 8'd0, 8'd0);
      send_word(OP_RENDER, '0, '0, 8'd0);
      send_word(OP_RENDER, '0, '0, 8'd143);
      set_all(8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'd0);
      send_word(OP_RENDER, '0, '0, 8'd0);
      send_word(OP_RENDER, '0, '0, 8'd255);
   endtask

   task automatic test_sprite_limit();
      // crowd one line with more sprites than fit
      for (int i = 0; i < 12; i++) begin
         send_word(OP_SPRITE_WRITE, 13'(i*4), 8'd56, 8'd0);
         send_word(OP_SPRITE_WRITE, 13'(i*4 + 1), 8'($urandom_range(0, 40)), 8'd0);
      end
      send_word(OP_RENDER, '0, '0, 8'd40);
      send_word(OP_RENDER, '0, '0, 8'd47);
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: set_all(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            1: set_all(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            2: set_all(8'h11, 8'hE4, 8'hE4, 8'h1B, 8'h10, 8'h20, 8'h8F);
            default: set_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom), 8'($urandom_range(0, 150)));
         endcase
         quiet_tx = (ph == 2);
         quiet_rx = (ph == 2);
         repeat (45) random_word();
      end
      quiet_tx = 1'b0;
      quiet_rx = 1'b0;
   endtask

   task automatic test_backpressure();
      hold_req = 1'b1;
      repeat (4) send_word(OP_RENDER, '0, '0, 8'($urandom_range(0, 143)));
      // sender waits for every group before going on
      wait_drained();
      repeat (10) random_word();
   endtask

   // receiver: random stalls, quiet stretches, and one long hold-off
   initial begin
      int r;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (quiet_rx || r < 70) begin
               rsp_chan.ready <= 1'b1;
            end else if (r < 96) begin
               rsp_chan.ready <= 1'b0;
               repeat ($urandom_range(0, 3)) @(negedge clock);
            end else begin
               rsp_chan.ready <= 1'b0;
               repeat ($urandom_range(20, 100)) @(negedge clock);
            end
         end
      end
   end

   // checker
   always @(posedge clock) begin
      group_word_t want;
      if (rsp_chan.valid && rsp_chan.ready) begin
         if (expected_groups.size() == 0) begin
            report_mismatch("unexpected group", rsp_chan.group_index, 0);
         end else begin
            want = expected_groups.pop_front();
            if (rsp_chan.group_index !== want.group_index)
               report_mismatch("group_index", rsp_chan.group_index, want.group_index);
            if (rsp_chan.pixel_shades !== want.pixel_shades)
               report_mismatch("pixel_shades", rsp_chan.pixel_shades, want.pixel_shades);
            if (rsp_chan.last !== want.last)
               report_mismatch("last", rsp_chan.last, want.last);
         end
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      foreach (tile_mem[i]) tile_mem[i] = 8'd0;
      foreach (sprite_tab[i]) sprite_tab[i] = 8'd0;
      regs[REG_LCD_CONTROL] = LCD_CONTROL_RST;
      regs[REG_BG_PALETTE] = BG_PALETTE_RST;
      regs[REG_OBJ_PAL_ZERO] = OBJ_PALETTE_RST;
      regs[REG_OBJ_PAL_ONE] = OBJ_PALETTE_RST;
      regs[REG_SCROLL_X] = 8'd0;
      regs[REG_SCROLL_Y] = 8'd0;
      regs[REG_WINDOW_TOP] = 8'd0;
      repeat (2) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      test_directed();
      test_sprite_limit();
      test_random_phases();
      test_backpressure();
      drop_valid();
      wait (expected_groups.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_groups.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* tile_sprite_scanline_renderer.f */
hdl/tssr_pkg.sv
hdl/tssr_req_if.sv
hdl/tssr_rsp_if.sv
hdl/tssr_ram.sv
hdl/tssr_ctrl.sv
hdl/tssr_datapath.sv
hdl/tile_sprite_scanline_renderer.sv
hdl/tssr_checker.sv
tb/tb_top.sv
